@@ hw/rtl/bmp_to_rgba_stream_decoder_macros.svh @@
// Assertion macros for the BMP to RGBA stream decoder.
// Used by the RTL files that carry concurrent assertions.
`ifndef BMP_TO_RGBA_STREAM_DECODER_MACROS_SVH
`define BMP_TO_RGBA_STREAM_DECODER_MACROS_SVH
`ifndef SYNTH
`define BMP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define BMP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define BMP_ASSERT(lbl, clk, rstn, prop)
`define BMP_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/bmpdec_pkg.sv @@
// Package of the BMP to RGBA stream decoder: phase codes, result kinds,
// error codes and header constants. No dependencies.
package bmpdec_pkg;
  localparam int unsigned MaxWidthDef   = 4096;
  localparam int unsigned MaxHeightDef  = 4096;
  localparam int unsigned PalEntriesDef = 256;
  localparam logic [31:0] HdrBytes  = 32'd54;
  localparam logic [31:0] PalEnd    = 32'd1078;
  localparam logic [63:0] MaxPixels = 64'h1FFF_FFFF;
  localparam logic [15:0] SigBm     = 16'h4D42;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_HEADER  = 7'b0000010,
    PH_CHECK   = 7'b0000100,
    PH_PALETTE = 7'b0001000,
    PH_SKIP    = 7'b0010000,
    PH_PIXELS  = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_PAL_SHORT = 4'd1, ERR_OFFSET = 4'd2, ERR_SIG = 4'd3,
    ERR_SIZE = 4'd4, ERR_COMPRESS = 4'd5, ERR_UNDER8 = 4'd6, ERR_DEPTH = 4'd7,
    ERR_DIMS = 4'd8, ERR_TRUNC = 4'd9
  } err_e;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  error_code;
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;
  } result_t;

  typedef struct packed {
    logic       start_of_file;
    logic [7:0] data_byte;
  } item_t;
endpackage

@@ hw/rtl/bmpdec_if.sv @@
// Valid/ready stream interface carrying one payload beat.
// Payload type is a parameter; uses nothing else.
interface bmpdec_if #(
  parameter type T = logic
) (
  input logic clk_i
);
  logic valid;
  logic ready;
  T     data;
  modport source (input clk_i, input ready, output valid, output data);
  modport sink (input clk_i, input valid, input data, output ready);
endinterface

@@ hw/rtl/bmpdec_palette.sv @@
// Palette memory: 256 x 24-bit, one write and one registered read port.
// Depends on bmpdec_pkg.
module bmpdec_palette import bmpdec_pkg::*; #(
  parameter int unsigned Entries = PalEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Entries)-1:0] waddr_i,
  input  logic [23:0]                wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Entries)-1:0] raddr_i,
  output logic [23:0]                rdata_o
);
  logic [23:0] mem [Entries];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/bmp_to_rgba_stream_decoder.sv @@
// BMP to RGBA stream decoder: one file byte per beat in, at most one result beat out.
// A result is registered and is valid the cycle after the byte that completes it; an 8-bit
// pixel also waits for the registered palette read and holds input while it waits. After
// byte 53 the header check runs in four steps (compare, multiply, size, issue) with input
// held; the header or error beat is issued in the last step. Otherwise one byte per cycle
// while output is free. Reset clears all control state; the palette memory is not cleared.
`include "bmp_to_rgba_stream_decoder_macros.svh"
module bmp_to_rgba_stream_decoder import bmpdec_pkg::*; #(
  parameter int unsigned MAX_WIDTH       = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT      = MaxHeightDef,
  parameter int unsigned PALETTE_ENTRIES = PalEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bmpdec_if.sink    in_i,
  bmpdec_if.source  out_o
);
  localparam int unsigned PalAw = $clog2(PALETTE_ENTRIES);

  phase_e      phase_q, phase_d;
  logic [31:0] flen_q, pos_q, dsize_q, doff_q, rwid_q, rhgt_q, comp_q;
  logic [31:0] flen_d, pos_d, dsize_d, doff_d, rwid_d, rhgt_d, comp_d;
  logic [15:0] sig_q, bpp_q, sig_d, bpp_d;
  logic [23:0] asm_q, rowbase_q, asm_d, rowbase_d;
  logic [15:0] col_q, row_q, cols_q, rows_q;
  logic [15:0] col_d, row_d, cols_d, rows_d;
  logic [1:0]  bip_q, bip_d;
  logic [1:0]  chk_q, chk_d;
  logic [3:0]  err_q, err_d;
  logic [31:0] npix_q, npix_d;
  logic [34:0] need_q, need_d;
  logic        out_vld_q, out_vld_d;
  result_t     out_q, out_d;
  logic        pend_q, pend_d;
  logic        pend_last_q, pend_last_d;
  logic [23:0] pend_idx_q, pend_idx_d;
  logic [23:0] pal_rd;
  logic [23:0] pal_wdata;
  logic [23:0] palw_q, palw_d;
  logic        pal_we;
  logic [PalAw-1:0] pal_waddr;

  logic        acc, out_free, sof;
  logic [7:0]  b;
  logic [31:0] pos_p1, pal_off;
  logic [31:0] rows_abs;
  logic        is8;
  logic [31:0] sig_w, bpp_w, palw_w, asm_w;
  logic        px_emit, px_last;
  logic [7:0]  px_r, px_g, px_b, px_a;
  logic [15:0] px_k;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] l, logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[l*8 +: 8] = v;
    return r;
  endfunction

  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = out_free && !pend_q && (phase_q != PH_CHECK);
  assign acc = in_i.valid && in_i.ready;
  assign sof = in_i.data.start_of_file;
  assign b   = in_i.data.data_byte;
  assign pos_p1 = pos_q + 32'd1;
  assign pal_off = pos_q - HdrBytes;
  assign is8 = (bpp_q == 16'd8);
  assign rows_abs = rhgt_q[31] ? (~rhgt_q + 32'd1) : rhgt_q;

  assign sig_w  = put_byte({16'd0, sig_q}, pos_q[1:0], b);
  assign bpp_w  = put_byte({16'd0, bpp_q}, 2'(pos_q - 32'd28), b);
  assign palw_w = put_byte({8'd0, palw_q}, pal_off[1:0], b);
  assign asm_w  = put_byte({8'd0, asm_q}, bip_q, b);

  // palette write: byte lanes gathered in palw_q, entry written on lane 2
  assign pal_we    = acc && !sof && phase_q == PH_PALETTE && pal_off[1:0] == 2'd2;
  assign pal_waddr = pal_off[PalAw+1:2];
  assign pal_wdata = {b, palw_q[15:0]};

  bmpdec_palette #(.Entries(PALETTE_ENTRIES)) u_pal (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(pal_wdata),
    .re_i   (acc && phase_q == PH_PIXELS && is8),
    .raddr_i(b[PalAw-1:0]),
    .rdata_o(pal_rd)
  );

  always_comb begin
    phase_d = phase_q; flen_d = flen_q; pos_d = pos_q; sig_d = sig_q; dsize_d = dsize_q;
    doff_d = doff_q; rwid_d = rwid_q; rhgt_d = rhgt_q; bpp_d = bpp_q; comp_d = comp_q;
    asm_d = asm_q; rowbase_d = rowbase_q; col_d = col_q; row_d = row_q; cols_d = cols_q;
    rows_d = rows_q; bip_d = bip_q; chk_d = chk_q; err_d = err_q; npix_d = npix_q;
    need_d = need_q; palw_d = palw_q; pend_d = pend_q; pend_last_d = pend_last_q;
    pend_idx_d = pend_idx_q; out_d = out_q;
    out_vld_d = out_vld_q && !out_o.ready;
    px_emit = 1'b0; px_r = '0; px_g = '0; px_b = '0; px_a = 8'hFF;
    px_k = {b, asm_q[7:0]};
    px_last = (row_q + 16'd1 >= rows_q) && (col_q + 16'd1 >= cols_q);

    if (cfg_we_i) flen_d = cfg_wdata_i;

    // palette pixel: the registered read data is ready in the cycle after the read
    if (pend_q && out_free) begin
      pend_d = 1'b0;
      out_vld_d = 1'b1;
      out_d = '0;
      out_d.result_kind = KIND_PIXEL;
      out_d.pixel_index = pend_idx_q;
      out_d.red = pal_rd[23:16];
      out_d.green = pal_rd[15:8];
      out_d.blue = pal_rd[7:0];
      out_d.alpha = 8'hFF;
      out_d.last_pixel = pend_last_q;
    end

    if (phase_q == PH_CHECK && out_free) begin
      unique case (chk_q)
        2'd0: begin
          if (is8 && PalEnd > flen_q) err_d = ERR_PAL_SHORT;
          else if (doff_q > flen_q || doff_q < (is8 ? PalEnd : HdrBytes))
            err_d = ERR_OFFSET;
          else if (sig_q != SigBm) err_d = ERR_SIG;
          else if (dsize_q != flen_q) err_d = ERR_SIZE;
          else if (comp_q != '0) err_d = ERR_COMPRESS;
          else if (bpp_q < 16'd8) err_d = ERR_UNDER8;
          else if (!(bpp_q == 16'd8 || bpp_q == 16'd16 || bpp_q == 16'd24 ||
                     bpp_q == 16'd32)) err_d = ERR_DEPTH;
          else if (rwid_q[31] || rwid_q == '0 || rows_abs == '0 ||
                   rwid_q > 32'(MAX_WIDTH) || rows_abs > 32'(MAX_HEIGHT))
            err_d = ERR_DIMS;
          else err_d = ERR_NONE;
          cols_d = rwid_q[15:0];
          rows_d = rows_abs[15:0];
          chk_d = 2'd1;
        end
        2'd1: begin
          npix_d = {16'd0, cols_q} * {16'd0, rows_q};
          chk_d = 2'd2;
        end
        2'd2: begin
          need_d = {3'd0, doff_q} + {3'd0, npix_q * {29'd0, bpp_q[5:3]}};
          chk_d = 2'd3;
        end
        default: begin
          chk_d = 2'd0;
          out_vld_d = 1'b1;
          out_d = '0;
          if (err_q == ERR_NONE && {32'd0, npix_q} > MaxPixels) begin
            out_d.result_kind = KIND_ERROR;
            out_d.error_code = ERR_DIMS;
            phase_d = PH_DONE;
          end else if (err_q == ERR_NONE && need_q > {3'd0, flen_q}) begin
            out_d.result_kind = KIND_ERROR;
            out_d.error_code = ERR_TRUNC;
            phase_d = PH_DONE;
          end else if (err_q != ERR_NONE) begin
            out_d.result_kind = KIND_ERROR;
            out_d.error_code = err_q;
            phase_d = PH_DONE;
          end else begin
            out_d.result_kind = KIND_HEADER;
            out_d.image_width = cols_q[12:0];
            out_d.image_height = rows_q[12:0];
            rowbase_d = npix_q[23:0] - 24'(cols_q);
            if (is8) phase_d = PH_PALETTE;
            else if (pos_q < doff_q) phase_d = PH_SKIP;
            else phase_d = PH_PIXELS;
          end
        end
      endcase
    end

    if (acc) begin
      if (sof) begin
        phase_d = PH_HEADER;
        pos_d = 32'd1; sig_d = {8'd0, b}; dsize_d = '0; doff_d = '0;
        rwid_d = '0; rhgt_d = '0; bpp_d = '0; comp_d = '0; asm_d = '0;
        col_d = '0; row_d = '0; rowbase_d = '0; bip_d = '0; chk_d = '0;
        cols_d = '0; rows_d = '0;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            pos_d = pos_p1;
            if (pos_p1 == HdrBytes) phase_d = PH_CHECK;
            if (pos_q < 32'd2) sig_d = sig_w[15:0];
            else if (pos_q < 32'd6) dsize_d = put_byte(dsize_q, 2'(pos_q - 32'd2), b);
            else if (pos_q >= 32'd10 && pos_q < 32'd14)
              doff_d = put_byte(doff_q, 2'(pos_q - 32'd10), b);
            else if (pos_q >= 32'd18 && pos_q < 32'd22)
              rwid_d = put_byte(rwid_q, 2'(pos_q - 32'd18), b);
            else if (pos_q >= 32'd22 && pos_q < 32'd26)
              rhgt_d = put_byte(rhgt_q, 2'(pos_q - 32'd22), b);
            else if (pos_q >= 32'd28 && pos_q < 32'd30)
              bpp_d = bpp_w[15:0];
            else if (pos_q >= 32'd30 && pos_q < 32'd34)
              comp_d = put_byte(comp_q, 2'(pos_q - 32'd30), b);
          end
          PH_PALETTE: begin
            pos_d = pos_p1;
            palw_d = palw_w[23:0];
            if (pos_p1 < PalEnd) phase_d = PH_PALETTE;
            else if (pos_p1 < doff_q) phase_d = PH_SKIP;
            else phase_d = PH_PIXELS;
          end
          PH_SKIP: begin
            pos_d = pos_p1;
            if (pos_p1 >= doff_q) phase_d = PH_PIXELS;
          end
          PH_PIXELS: begin
            if (is8) begin
              px_emit = 1'b1;
            end else if (bpp_q == 16'd16) begin
              if (bip_q == 2'd0) begin
                asm_d = {16'd0, b}; bip_d = 2'd1;
              end else begin
                bip_d = 2'd0; px_emit = 1'b1;
                px_r = {px_k[14:10], 3'd0};
                px_g = {px_k[9:5], 3'd0};
                px_b = {px_k[4:0], 3'd0};
              end
            end else if (bip_q < 2'd2 || (bpp_q == 16'd32 && bip_q == 2'd2)) begin
              asm_d = asm_w[23:0];
              bip_d = bip_q + 2'd1;
            end else begin
              bip_d = 2'd0; px_emit = 1'b1;
              if (bpp_q == 16'd24) begin
                px_r = b; px_g = asm_q[15:8]; px_b = asm_q[7:0];
              end else begin
                px_r = asm_q[23:16]; px_g = asm_q[15:8]; px_b = asm_q[7:0]; px_a = b;
              end
            end
            if (px_emit) begin
              if (is8) begin
                pend_d = 1'b1;
                pend_last_d = px_last;
                pend_idx_d = rowbase_q + 24'(col_q);
              end else begin
                out_vld_d = 1'b1;
                out_d = '0;
                out_d.result_kind = KIND_PIXEL;
                out_d.pixel_index = rowbase_q + 24'(col_q);
                out_d.red = px_r; out_d.green = px_g; out_d.blue = px_b; out_d.alpha = px_a;
                out_d.last_pixel = px_last;
              end
              if (px_last) begin
                phase_d = PH_DONE;
              end else if (col_q + 16'd1 >= cols_q) begin
                col_d = '0;
                row_d = row_q + 16'd1;
                rowbase_d = rowbase_q - 24'(cols_q);
              end else begin
                col_d = col_q + 16'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      flen_q <= '0; pos_q <= '0; sig_q <= '0; dsize_q <= '0; doff_q <= '0;
      rwid_q <= '0; rhgt_q <= '0; bpp_q <= '0; comp_q <= '0; asm_q <= '0;
      col_q <= '0; row_q <= '0; rowbase_q <= '0; bip_q <= '0;
      cols_q <= '0; rows_q <= '0; chk_q <= '0; err_q <= ERR_NONE;
      npix_q <= '0; need_q <= '0; out_vld_q <= 1'b0; out_q <= '0;
      pend_q <= 1'b0; pend_last_q <= 1'b0; pend_idx_q <= '0; palw_q <= '0;
    end else begin
      phase_q <= phase_d;
      flen_q <= flen_d; pos_q <= pos_d; sig_q <= sig_d; dsize_q <= dsize_d; doff_q <= doff_d;
      rwid_q <= rwid_d; rhgt_q <= rhgt_d; bpp_q <= bpp_d; comp_q <= comp_d; asm_q <= asm_d;
      col_q <= col_d; row_q <= row_d; rowbase_q <= rowbase_d; bip_q <= bip_d;
      cols_q <= cols_d; rows_q <= rows_d; chk_q <= chk_d; err_q <= err_d;
      npix_q <= npix_d; need_q <= need_d; out_vld_q <= out_vld_d; out_q <= out_d;
      pend_q <= pend_d; pend_last_q <= pend_last_d; pend_idx_q <= pend_idx_d; palw_q <= palw_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  `BMP_ASSERT(a_no_accept_in_check, clk_i, rst_ni, (phase_q == PH_CHECK) |-> !in_i.ready)
  `BMP_ASSERT(a_pend_blocks, clk_i, rst_ni, pend_q |-> !in_i.ready)
  `BMP_ASSERT(a_pend_is_pixel, clk_i, rst_ni, $fell(pend_q) |-> out_vld_q)
  `BMP_ASSERT(a_chk_idle, clk_i, rst_ni, (phase_q != PH_CHECK) |-> (chk_q == 2'd0))
endmodule
